FILE: sv/spd_pkg.sv
`default_nettype none
package spd_pkg;

    // Line control characters
    localparam logic [7:0] SYN_CH = 8'h16;
    localparam logic [7:0] DLE_CH = 8'h10;
    localparam logic [7:0] ETX_CH = 8'h03;
    localparam logic [7:0] XOFF_CH = 8'h13;
    localparam logic [7:0] XON_CH = 8'h11;

    // Characters that follow DLE in an escape
    localparam logic [7:0] ESC_SYN = 8'h53;  // 'S'
    localparam logic [7:0] ESC_DLE = 8'h44;  // 'D'
    localparam logic [7:0] ESC_ETX = 8'h43;  // 'C'
    localparam logic [7:0] ESC_XOFF = 8'h73; // 's'
    localparam logic [7:0] ESC_XON = 8'h71;  // 'q'

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_SEQUENCE = 2'd2;
    localparam int CFG_DATA_W = 11;

    // Wanted packet type codes
    localparam logic [1:0] ACC_DATA = 2'd0;
    localparam logic [1:0] ACC_ACK = 2'd1;
    localparam logic [1:0] ACC_ANY = 2'd2;

    // Field widths
    localparam int LEN_W = 11;
    localparam int SEQ_W = 6;
    localparam int SUM_W = 18;

    // Report status codes
    typedef enum logic [2:0] {
        ST_GOOD = 3'd0,
        ST_BAD_TYPE = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_SEQUENCE = 3'd3,
        ST_BAD_CHECKSUM = 3'd4
    } t_status;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_HUNT = 8'b0000_0001,
        PH_TYPE = 8'b0000_0010,
        PH_LEN1 = 8'b0000_0100,
        PH_SEQ = 8'b0000_1000,
        PH_DATA = 8'b0001_0000,
        PH_CS0 = 8'b0010_0000,
        PH_CS1 = 8'b0100_0000,
        PH_CS2 = 8'b1000_0000
    } t_phase;

    // Classified line word passed from front to back
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] unesc;
        logic       is_syn;
        logic       is_dle;
    } t_word;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
    } t_q_stat;

    // Queue head seen by the back
    typedef struct packed {
        logic  empty;
        t_word head;
    } t_q_head;

    // Result held in the output register
    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        t_status          status;
        logic             packet_type;
        logic [LEN_W-1:0] length;
        logic             send_ack;
        logic [SEQ_W-1:0] ack_sequence;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/spd_in_if.sv
`default_nettype none
interface spd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: sv/spd_out_if.sv
`default_nettype none
interface spd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic        packet_type;
    logic [10:0] length;
    logic        send_ack;
    logic [5:0]  ack_sequence;

    modport source(output valid, output kind, output data_byte, output status,
                   output packet_type, output length, output send_ack,
                   output ack_sequence, input ready);
    modport sink(input valid, input kind, input data_byte, input status,
                 input packet_type, input length, input send_ack,
                 input ack_sequence, output ready);
endinterface
`default_nettype wire

FILE: sv/spd_front.sv
`default_nettype none
module spd_front
    import spd_pkg::*;
(
    spd_in_if.sink  i_rx,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_word   o_word
);

    // Decode the character that follows DLE
    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            ESC_SYN:  r = SYN_CH;
            ESC_DLE:  r = DLE_CH;
            ESC_ETX:  r = ETX_CH;
            ESC_XOFF: r = XOFF_CH;
            ESC_XON:  r = XON_CH;
            default:  r = c;
        endcase
        return r;
    endfunction

    // Take a word whenever the queue has room
    assign i_rx.ready = !i_q_stat.full;
    assign o_push = i_rx.valid && !i_q_stat.full;

    // Classify the raw byte
    assign o_word.raw = i_rx.rx_byte;
    assign o_word.unesc = unescape(i_rx.rx_byte);
    assign o_word.is_syn = (i_rx.rx_byte == SYN_CH);
    assign o_word.is_dle = (i_rx.rx_byte == DLE_CH);

endmodule
`default_nettype wire

FILE: sv/spd_queue.sv
`default_nettype none
module spd_queue
    import spd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_word   i_word,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_q_head o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_word            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_stat.full = (r_count == FULL_CNT);
    assign o_head.empty = (r_count == '0);
    assign o_head.head = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

FILE: sv/spd_back.sv
`default_nettype none
module spd_back
    import spd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_head               i_q_head,
    output logic                  o_pop,
    spd_out_if.source             o_res
);

    logic [1:0]       r_accept_type;
    logic [LEN_W-1:0] r_max_length;
    logic [SEQ_W-1:0] r_tx_sequence;

    t_phase           r_phase, n_phase;
    logic             r_esc, n_esc;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SUM_W-1:0] r_cap_sum, n_cap_sum;
    logic [SUM_W-1:0] r_rcv_sum, n_rcv_sum;
    logic             r_hdr_type, n_hdr_type;
    logic [LEN_W-1:0] r_frame_len, n_frame_len;
    logic [LEN_W-1:0] r_bytes_left, n_bytes_left;
    logic [SEQ_W-1:0] r_exp_seq, n_exp_seq;

    logic             r_out_valid;
    t_result          r_res;

    logic             emit;
    t_result          res;
    t_word            w;
    logic [7:0]       c;
    logic [SUM_W-1:0] sum_add;
    logic             want;
    logic [LEN_W-1:0] len_full;
    logic [SEQ_W-1:0] want_seq;
    logic [LEN_W-1:0] left_dec;
    logic [SUM_W-1:0] rcv_full;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_type <= ACC_ANY;
            r_max_length <= LEN_W'(1023);
            r_tx_sequence <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACCEPT_TYPE: r_accept_type <= i_cfg_data[1:0];
                CFG_MAX_LENGTH:  r_max_length <= i_cfg_data[LEN_W-1:0];
                CFG_TX_SEQUENCE: r_tx_sequence <= i_cfg_data[SEQ_W-1:0];
                default:         ;
            endcase
        end
    end

    // Take a word when the output register is free or being drained
    assign o_pop = !i_q_head.empty && (!r_out_valid || o_res.ready);
    assign w = i_q_head.head;
    assign c = r_esc ? w.unesc : w.raw;
    assign sum_add = r_sum + {{(SUM_W-8){1'b0}}, w.raw};
    assign len_full = {r_frame_len[LEN_W-1:6], c[5:0]};
    assign want_seq = r_hdr_type ? r_exp_seq : r_tx_sequence + 1'b1;
    assign left_dec = r_bytes_left - 1'b1;
    assign rcv_full = {r_rcv_sum[SUM_W-1:6], c[5:0]};

    // Parse one classified word
    always_comb begin
        n_phase = r_phase;
        n_esc = r_esc;
        n_sum = r_sum;
        n_cap_sum = r_cap_sum;
        n_rcv_sum = r_rcv_sum;
        n_hdr_type = r_hdr_type;
        n_frame_len = r_frame_len;
        n_bytes_left = r_bytes_left;
        n_exp_seq = r_exp_seq;
        emit = 1'b0;
        want = 1'b0;
        res = '0;
        res.kind = 1'b1;
        res.status = ST_GOOD;
        res.packet_type = r_hdr_type;
        res.send_ack = r_hdr_type;
        res.ack_sequence = r_exp_seq;
        res.length = r_frame_len;
        if (o_pop) begin
            if (w.is_syn) begin
                // restart the header on any raw SYN
                n_phase = PH_TYPE;
                n_sum = '0;
                n_esc = 1'b0;
            end else if (r_phase == PH_HUNT) begin
                // drop bytes while hunting
            end else if (w.is_dle) begin
                n_sum = sum_add;
                n_esc = 1'b1;
            end else begin
                n_sum = sum_add;
                n_esc = 1'b0;
                case (r_phase)
                    PH_TYPE: begin
                        n_hdr_type = c[5];
                        n_frame_len = {c[4:0], 6'b0};
                        case (r_accept_type)
                            ACC_DATA: want = 1'b1;
                            ACC_ACK:  want = 1'b0;
                            default:  want = c[5];
                        endcase
                        if (want != c[5]) begin
                            emit = 1'b1;
                            res.status = ST_BAD_TYPE;
                            res.packet_type = c[5];
                            res.send_ack = c[5];
                            res.length = '0;
                            n_phase = PH_HUNT;
                        end else begin
                            n_phase = PH_LEN1;
                        end
                    end
                    PH_LEN1: begin
                        n_frame_len = len_full;
                        res.length = len_full;
                        if (len_full > r_max_length) begin
                            emit = 1'b1;
                            res.status = ST_BAD_LENGTH;
                            n_phase = PH_HUNT;
                        end else begin
                            n_phase = PH_SEQ;
                        end
                    end
                    PH_SEQ: begin
                        if (c[SEQ_W-1:0] != want_seq) begin
                            emit = 1'b1;
                            res.status = ST_BAD_SEQUENCE;
                            n_phase = PH_HUNT;
                        end else if (r_frame_len == '0) begin
                            n_cap_sum = sum_add;
                            n_rcv_sum = '0;
                            n_phase = PH_CS0;
                        end else begin
                            n_bytes_left = r_frame_len;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        emit = 1'b1;
                        res = '0;
                        res.kind = 1'b0;
                        res.status = ST_GOOD;
                        res.data_byte = c;
                        n_bytes_left = left_dec;
                        if (left_dec == '0) begin
                            n_cap_sum = sum_add;
                            n_rcv_sum = '0;
                            n_phase = PH_CS0;
                        end
                    end
                    PH_CS0: begin
                        n_rcv_sum = {c[5:0], 12'b0};
                        n_phase = PH_CS1;
                    end
                    PH_CS1: begin
                        n_rcv_sum = {r_rcv_sum[SUM_W-1:12], c[5:0], 6'b0};
                        n_phase = PH_CS2;
                    end
                    PH_CS2: begin
                        n_rcv_sum = rcv_full;
                        emit = 1'b1;
                        n_phase = PH_HUNT;
                        if (r_cap_sum != rcv_full) begin
                            res.status = ST_BAD_CHECKSUM;
                        end else if (r_hdr_type) begin
                            n_exp_seq = r_exp_seq + 1'b1;
                            res.ack_sequence = r_exp_seq + 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_esc <= 1'b0;
            r_sum <= '0;
            r_cap_sum <= '0;
            r_rcv_sum <= '0;
            r_hdr_type <= 1'b0;
            r_frame_len <= '0;
            r_bytes_left <= '0;
            r_exp_seq <= '0;
        end else begin
            r_phase <= n_phase;
            r_esc <= n_esc;
            r_sum <= n_sum;
            r_cap_sum <= n_cap_sum;
            r_rcv_sum <= n_rcv_sum;
            r_hdr_type <= n_hdr_type;
            r_frame_len <= n_frame_len;
            r_bytes_left <= n_bytes_left;
            r_exp_seq <= n_exp_seq;
        end
    end

    // Load or drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.kind = r_res.kind;
    assign o_res.data_byte = r_res.data_byte;
    assign o_res.status = r_res.status;
    assign o_res.packet_type = r_res.packet_type;
    assign o_res.length = r_res.length;
    assign o_res.send_ack = r_res.send_ack;
    assign o_res.ack_sequence = r_res.ack_sequence;

endmodule
`default_nettype wire

FILE: sv/stuffed_packet_deframer.sv
// Receive deframer for a DLE byte-stuffed serial packet link.
// i_rx carries one raw line byte per word; o_res carries either a decoded
// payload byte (kind 0) or an end-of-packet report (kind 1) with status,
// type, length and an ack request for data packets. Both channels move a
// word at a rising edge where valid and ready are both high.
// Configuration (accept type, maximum length, transmit sequence) is written
// through i_cfg_we / i_cfg_index / i_cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Throughput is one byte per cycle unless the receiver stalls. A byte
// accepted into the classification queue is taken by the parser, and its
// result, if any, is registered in the output register. The parser handles
// one queued word per cycle; the rate falls below that only while the
// receiver stalls. Reset (synchronous, i_rst_n low) empties the queue and
// the output register, restores the register defaults and puts the parser
// into sync hunting. When the receiver stalls, the output register holds
// its word, the parser stops taking words, the queue fills (QUEUE_DEPTH
// words) and i_rx.ready falls.
`default_nettype none
module stuffed_packet_deframer
    import spd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    spd_in_if.sink                i_rx,
    spd_out_if.source             o_res
);

    logic    push;
    logic    pop;
    t_word   word;
    t_q_stat q_stat;
    t_q_head q_head;

    // Classify incoming bytes
    spd_front u_front (
        .i_rx     (i_rx),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_word   (word)
    );

    // Decouple front from parser
    spd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (word),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (q_head)
    );

    // Parse packets and drive results
    spd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
